>>> rtl/core/tes_pkg.sv
`default_nettype none

package tes_pkg;

  localparam logic [15:0] MIN_SPACING_RST  = 16'd10;
  localparam logic [1:0]  ADDR_MIN_SPACING = 2'd0;

  typedef enum logic [2:0] {
    FN_INSERT = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_START  = 3'd2,
    FN_STOP   = 3'd3,
    FN_TICK   = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    ST_INSERTED = 4'd0,
    ST_LOCKED   = 4'd1,
    ST_EARLY    = 4'd2,
    ST_CLOSE    = 4'd3,
    ST_FULL     = 4'd4,
    ST_STARTED  = 4'd5,
    ST_REFUSED  = 4'd6,
    ST_STOPPED  = 4'd7,
    ST_CLEARED  = 4'd8,
    ST_FIRED    = 4'd9
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_SHIFT,
    S_WRITE,
    S_TICK_CMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic lt;     // a below b
    logic close;  // |a - b| below half interval
  } cmp_res_t;

endpackage

`default_nettype wire

>>> rtl/core/tes_cmp_unit.sv
`default_nettype none

module tes_cmp_unit
  import tes_pkg::*;
#(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [15:0]  half,
  output cmp_res_t     res
);

  logic         lt;
  logic [W-1:0] diff;

  assign lt   = a < b;
  assign diff = lt ? (b - a) : (a - b);

  assign res.lt    = lt;
  assign res.close = diff < W'(half);

endmodule

`default_nettype wire

>>> rtl/core/tes_event_ram.sv
`default_nettype none

module tes_event_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/core/timed_event_sequencer.sv
// Timed event sequencer: a sorted table of event times in ticks, played back.
// Requests enter on in_valid/in_stall with in_func (insert, clear, start,
// stop, tick), in_time_value and in_force_req. At most one result per request
// leaves on out_valid/out_stall as out_status, out_index, out_done_res.
// The minimum spacing is written over the APB port at byte address 0, by the
// user only while idle; the block itself does not enforce this.
// An insert walks the table through one compare unit and one RAM port: the
// scan reads one entry a cycle and, unless the new time lands at the end, the
// shift moves one entry a cycle. in_stall is high while a request is in work.
// The result sits in an output register; while out_stall holds it, the block
// still takes the next request and parks that result until the register
// frees up. Reset clears the table count, the run state and the elapsed
// count, and sets the minimum spacing to 10; table contents are not cleared.
`default_nettype none

module timed_event_sequencer
  import tes_pkg::*;
#(
  parameter int MAX_EVENTS = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_time_value,
  input  logic        in_force_req,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [5:0]  out_index,
  output logic        out_done_res,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IW   = $clog2(MAX_EVENTS);
  localparam int CW   = $clog2(MAX_EVENTS + 1);
  localparam int TW   = TIME_WIDTH;
  localparam int CMPW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_EVENTS);

  state_t          state_r, state_nxt;
  logic [15:0]     min_int_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            running_r, running_nxt;
  logic [CW-1:0]   next_r, next_nxt;
  logic [TW-1:0]   elapsed_r, elapsed_nxt;
  logic [TW-1:0]   t_r, t_nxt;
  logic [IW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [IW-1:0]   j_r, j_nxt;
  status_t         res_status_r, res_status_nxt;
  logic [5:0]      res_index_r, res_index_nxt;
  logic            res_done_r, res_done_nxt;

  logic            out_valid_r;
  status_t         out_status_r;
  logic [5:0]      out_index_r;
  logic            out_done_r;

  logic            in_acc;
  logic            out_free;
  logic            cfg_wr;
  logic [16:0]     half_sum;
  logic [15:0]     half;
  logic [TW-1:0]   t_in;
  logic [IW:0]     i_inc;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   next_inc;

  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [TW-1:0]   wr_data;
  logic [IW-1:0]   rd_addr;
  logic [TW-1:0]   rd_data;

  logic [CMPW-1:0] cmp_a, cmp_b;
  cmp_res_t        cmp;

  tes_event_ram #(
    .DEPTH (MAX_EVENTS),
    .WIDTH (TW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tes_cmp_unit #(
    .W (CMPW)
  ) u_cmp (
    .a    (cmp_a),
    .b    (cmp_b),
    .half (half),
    .res  (cmp)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == ADDR_MIN_SPACING);
  assign cfg_prdata = {16'd0, min_int_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r <= MIN_SPACING_RST;
    end else if (cfg_wr && (cfg_pwdata[15:0] != 16'd0)) begin
      min_int_r <= cfg_pwdata[15:0];
    end
  end

  // half window rounded up: t < m/2 exactly when t < (m+1)>>1
  assign half_sum = {1'b0, min_int_r} + 17'd1;
  assign half     = half_sum[16:1];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign t_in     = TW'(in_time_value);
  assign i_inc    = {1'b0, i_r} + 1'b1;
  assign cnt_m1   = count_r - 1'b1;
  assign next_inc = next_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    running_nxt    = running_r;
    next_nxt       = next_r;
    elapsed_nxt    = elapsed_r;
    t_nxt          = t_r;
    i_nxt          = i_r;
    pos_nxt        = pos_r;
    j_nxt          = j_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_done_nxt   = res_done_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r[IW-1:0];
    wr_data        = t_r;
    rd_addr        = '0;
    cmp_a          = CMPW'(t_in);
    cmp_b          = CMPW'(half);

    case (state_r)
      S_IDLE: begin
        rd_addr = (in_func == FN_TICK) ? next_r[IW-1:0] : '0;
        if (in_acc) begin
          res_index_nxt = '0;
          res_done_nxt  = 1'b0;
          case (in_func)
            FN_INSERT: begin
              t_nxt   = t_in;
              i_nxt   = '0;
              pos_nxt = '0;
              if (running_r) begin
                res_status_nxt = ST_LOCKED;
                state_nxt      = S_EMIT;
              end else if (cmp.lt) begin
                res_status_nxt = ST_EARLY;
                state_nxt      = S_EMIT;
              end else if (count_r == '0) begin
                state_nxt = S_PLACE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            FN_CLEAR: begin
              if (running_r) begin
                res_status_nxt = ST_LOCKED;
              end else begin
                count_nxt      = '0;
                res_status_nxt = ST_CLEARED;
              end
              state_nxt = S_EMIT;
            end
            FN_START: begin
              if (running_r && !in_force_req) begin
                res_status_nxt = ST_REFUSED;
              end else if (count_r == '0) begin
                running_nxt    = 1'b0;
                res_status_nxt = ST_REFUSED;
              end else begin
                elapsed_nxt    = '0;
                next_nxt       = '0;
                running_nxt    = 1'b1;
                res_status_nxt = ST_STARTED;
              end
              state_nxt = S_EMIT;
            end
            FN_STOP: begin
              running_nxt    = 1'b0;
              res_status_nxt = ST_STOPPED;
              state_nxt      = S_EMIT;
            end
            FN_TICK: begin
              if (running_r) begin
                if (elapsed_r != {TW{1'b1}}) begin
                  elapsed_nxt = elapsed_r + 1'b1;
                end
                if (next_r >= count_r) begin
                  running_nxt = 1'b0;
                end else begin
                  state_nxt = S_TICK_CMP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // entry i_r is on the read port; fetch the following one
        cmp_a   = CMPW'(rd_data);
        cmp_b   = CMPW'(t_r);
        rd_addr = i_inc[IW-1:0];
        if (cmp.close) begin
          res_status_nxt = ST_CLOSE;
          state_nxt      = S_EMIT;
        end else begin
          pos_nxt = pos_r + CW'(cmp.lt);
          if (CW'(i_inc) < count_r) begin
            i_nxt = i_inc[IW-1:0];
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        rd_addr = cnt_m1[IW-1:0];
        if (count_r == MAX_CNT) begin
          res_status_nxt = ST_FULL;
          state_nxt      = S_EMIT;
        end else if (pos_r == count_r) begin
          wr_en          = 1'b1;
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_INSERTED;
          res_index_nxt  = 6'(pos_r);
          state_nxt      = S_EMIT;
        end else begin
          j_nxt     = cnt_m1[IW-1:0];
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // move entry j_r up one place, walking down to the insert position
        wr_en   = 1'b1;
        wr_addr = j_r + 1'b1;
        wr_data = rd_data;
        rd_addr = j_r - 1'b1;
        if (CW'(j_r) == pos_r) begin
          state_nxt = S_WRITE;
        end else begin
          j_nxt = j_r - 1'b1;
        end
      end

      S_WRITE: begin
        wr_en          = 1'b1;
        count_nxt      = count_r + 1'b1;
        res_status_nxt = ST_INSERTED;
        res_index_nxt  = 6'(pos_r);
        state_nxt      = S_EMIT;
      end

      S_TICK_CMP: begin
        cmp_a = CMPW'(elapsed_r);
        cmp_b = CMPW'(rd_data);
        if (cmp.lt) begin
          state_nxt = S_IDLE;
        end else begin
          res_status_nxt = ST_FIRED;
          res_index_nxt  = 6'(next_r);
          next_nxt       = next_inc;
          if (next_inc >= count_r) begin
            res_done_nxt = 1'b1;
            running_nxt  = 1'b0;
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      running_r <= 1'b0;
      next_r    <= '0;
      elapsed_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
      next_r    <= next_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    i_r          <= i_nxt;
    pos_r        <= pos_nxt;
    j_r          <= j_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_done_r   <= res_done_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_done_r   <= res_done_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_index    = out_index_r;
  assign out_done_res = out_done_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("entry count above table depth");

  a_run_next: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (next_r < count_r))
    else $error("active run points past the last entry");

  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (pos_r < count_r))
    else $error("shift with insert position at table end");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("result shown without a pending result");

endmodule

`default_nettype wire

>>> dv/timed_event_sequencer_tb.sv
module timed_event_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tes_pkg::*;

  localparam int TBL_DEPTH    = 64;
  localparam int DRAIN_CYCLES = 300;   // longest insert: full scan and shift of 63 entries
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int N_PHASES     = 8;

  localparam logic [2:0] FN_RSV5 = 3'd5;
  localparam logic [2:0] FN_RSV6 = 3'd6;
  localparam logic [2:0] FN_RSV7 = 3'd7;

  typedef struct packed {
    status_t    status;
    logic [5:0] idx;
    logic       done;
  } outcome_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] tv;
    logic        frc;
    logic        pinned;  // expected outcome typed in below
    logic        quiet;   // pinned request that yields nothing
    outcome_t    res;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  localparam outcome_t NO_RESULT = '{ST_INSERTED, 6'd0, 1'b0};

  // minimum spacing is 10 here, so the rejection window is 5
  localparam dir_row_t DIR_TBL [26] = '{
    '{FN_TICK,   32'd0,          1'b0, 1'b1, 1'b1, NO_RESULT},
    '{FN_START,  32'd0,          1'b0, 1'b1, 1'b0, '{ST_REFUSED,  6'd0, 1'b0}},
    '{FN_START,  32'd0,          1'b1, 1'b1, 1'b0, '{ST_REFUSED,  6'd0, 1'b0}},
    '{FN_INSERT, 32'd0,          1'b0, 1'b1, 1'b0, '{ST_EARLY,    6'd0, 1'b0}},
    '{FN_INSERT, 32'd4,          1'b0, 1'b1, 1'b0, '{ST_EARLY,    6'd0, 1'b0}},
    '{FN_INSERT, 32'd5,          1'b0, 1'b1, 1'b0, '{ST_INSERTED, 6'd0, 1'b0}},
    '{FN_INSERT, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, '{ST_INSERTED, 6'd1, 1'b0}},
    '{FN_INSERT, 32'd9,          1'b0, 1'b1, 1'b0, '{ST_CLOSE,    6'd0, 1'b0}},
    '{FN_INSERT, 32'hFFFF_FFFB,  1'b0, 1'b1, 1'b0, '{ST_CLOSE,    6'd0, 1'b0}},
    '{FN_INSERT, 32'd10,         1'b0, 1'b1, 1'b0, '{ST_INSERTED, 6'd1, 1'b0}},
    '{FN_CLEAR,  32'd0,          1'b0, 1'b1, 1'b0, '{ST_CLEARED,  6'd0, 1'b0}},
    '{FN_STOP,   32'd0,          1'b0, 1'b1, 1'b0, '{ST_STOPPED,  6'd0, 1'b0}},
    '{FN_INSERT, 32'd20,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FN_INSERT, 32'd8,          1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FN_INSERT, 32'd14,         1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FN_START,  32'd0,          1'b1, 1'b1, 1'b0, '{ST_STARTED,  6'd0, 1'b0}},
    '{FN_INSERT, 32'd30,         1'b0, 1'b1, 1'b0, '{ST_LOCKED,   6'd0, 1'b0}},
    '{FN_CLEAR,  32'd0,          1'b0, 1'b1, 1'b0, '{ST_LOCKED,   6'd0, 1'b0}},
    '{FN_START,  32'd0,          1'b0, 1'b1, 1'b0, '{ST_REFUSED,  6'd0, 1'b0}},
    '{FN_START,  32'd0,          1'b1, 1'b1, 1'b0, '{ST_STARTED,  6'd0, 1'b0}},
    '{FN_TICK,   32'd0,          1'b0, 1'b0, 1'b0, NO_RESULT},
    '{FN_RSV5,   32'hAAAA_AAAA,  1'b1, 1'b1, 1'b1, NO_RESULT},
    '{FN_RSV6,   32'd0,          1'b0, 1'b1, 1'b1, NO_RESULT},
    '{FN_RSV7,   32'h5555_5555,  1'b1, 1'b1, 1'b1, NO_RESULT},
    '{FN_STOP,   32'd0,          1'b0, 1'b1, 1'b0, '{ST_STOPPED,  6'd0, 1'b0}},
    '{FN_TICK,   32'd0,          1'b0, 1'b0, 1'b0, NO_RESULT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = FN_INSERT;
  logic [31:0] in_time_value = 32'd0;
  logic        in_force_req = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_status;
  logic [5:0]  out_index;
  logic        out_done_res;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = ADDR_MIN_SPACING;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predicted sequencer state
  logic [31:0] ev_time [TBL_DEPTH];
  int unsigned n_entries = 0;
  bit          seq_active = 1'b0;
  int unsigned next_due = 0;
  logic [31:0] elapsed_ticks = 32'd0;
  logic [15:0] min_iv = MIN_SPACING_RST;

  outcome_t    pending_outcomes [$];
  int          fail_cnt = 0;
  int          n_items = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  rx_mode_t    stall_mode = RX_OPEN;
  int          mode_left = 0;
  logic [7:0]  stall_phase = 8'd0;

  timed_event_sequencer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit apply_request(input logic [2:0] f, input logic [31:0] t,
                                       input logic fr, output outcome_t o);
    logic [31:0] half;
    logic [31:0] sep;
    int unsigned pos;
    o = NO_RESULT;
    half = ({16'd0, min_iv} + 32'd1) >> 1;
    case (f)
      FN_INSERT: begin
        if (seq_active) begin
          o.status = ST_LOCKED;
          return 1'b1;
        end
        if (t < half) begin
          o.status = ST_EARLY;
          return 1'b1;
        end
        pos = 0;
        for (int unsigned i = 0; i < n_entries; i++) begin
          sep = (t >= ev_time[i]) ? t - ev_time[i] : ev_time[i] - t;
          if (sep < half) begin
            o.status = ST_CLOSE;
            return 1'b1;
          end
          if (ev_time[i] < t) pos = i + 1;
        end
        if (n_entries >= TBL_DEPTH) begin
          o.status = ST_FULL;
          return 1'b1;
        end
        for (int unsigned i = n_entries; i > pos; i--) ev_time[i] = ev_time[i-1];
        ev_time[pos] = t;
        n_entries++;
        o.idx = 6'(pos);
        return 1'b1;
      end
      FN_CLEAR: begin
        if (seq_active) begin
          o.status = ST_LOCKED;
        end else begin
          n_entries = 0;
          o.status = ST_CLEARED;
        end
        return 1'b1;
      end
      FN_START: begin
        if (seq_active) begin
          if (!fr) begin
            o.status = ST_REFUSED;
            return 1'b1;
          end
          seq_active = 1'b0;
        end
        if (n_entries == 0) begin
          o.status = ST_REFUSED;
        end else begin
          elapsed_ticks = 32'd0;
          next_due = 0;
          seq_active = 1'b1;
          o.status = ST_STARTED;
        end
        return 1'b1;
      end
      FN_STOP: begin
        seq_active = 1'b0;
        o.status = ST_STOPPED;
        return 1'b1;
      end
      FN_TICK: begin
        if (!seq_active) return 1'b0;
        if (elapsed_ticks != '1) elapsed_ticks++;
        if (next_due >= n_entries) begin
          seq_active = 1'b0;
          return 1'b0;
        end
        if (elapsed_ticks < ev_time[next_due]) return 1'b0;
        o.status = ST_FIRED;
        o.idx = 6'(next_due);
        next_due++;
        if (next_due >= n_entries) begin
          o.done = 1'b1;
          seq_active = 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
    return 1'b0;
  endfunction

  function automatic void queue_outcome(input outcome_t o);
    pending_outcomes = {pending_outcomes, o};
  endfunction

  task automatic send_req(input logic [2:0] f, input logic [31:0] t, input logic fr,
                          input logic pinned = 1'b0, input logic quiet = 1'b0,
                          input outcome_t pin = NO_RESULT);
    int gap;
    bit got;
    outcome_t o;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_func       <= f;
    in_time_value <= t;
    in_force_req  <= fr;
    do @(posedge clk); while (in_stall);
    got = apply_request(f, t, fr, o);
    if (pinned) begin
      if (!quiet) queue_outcome(pin);
    end else if (got) begin
      queue_outcome(o);
    end
    if (f < FN_RSV5) n_items++;
  endtask

  // hold the request line low until every outcome is back, then let the block settle
  task automatic drain(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_outcomes.size() == 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ADDR_MIN_SPACING;
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      if (val[15:0] != 16'd0) min_iv = val[15:0];
    end else if (cfg_prdata !== {16'd0, min_iv}) begin
      $error("min_spacing: expected %0d, got %0d", min_iv, cfg_prdata);
      fail_cnt++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // stop, clear, load a few times, start and tick; short runs are ticked out
  task automatic play_sequence();
    int n_ticks;
    logic [31:0] t;
    logic [31:0] half;
    half = ({16'd0, min_iv} + 32'd1) >> 1;
    send_req(FN_STOP, $urandom, 1'($urandom_range(0, 1)));
    send_req(FN_CLEAR, $urandom, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 10)) begin
      if (half > 64)
        t = ($urandom_range(0, 7) == 0) ? $urandom_range(0, half) : $urandom;
      else if ($urandom_range(0, 11) == 0)
        t = $urandom;
      else
        t = $urandom_range(0, 60 + 4 * min_iv);
      send_req(FN_INSERT, t, 1'($urandom_range(0, 1)));
    end
    send_req(FN_START, $urandom, 1'($urandom_range(0, 1)));
    if (n_entries > 0 && ev_time[n_entries-1] <= 300)
      n_ticks = ev_time[n_entries-1] + $urandom_range(0, 3);
    else
      n_ticks = $urandom_range(5, 40);
    repeat (n_ticks) begin
      // poke the locked table now and then
      if ($urandom_range(0, 15) == 0)
        send_req(3'($urandom_range(FN_INSERT, FN_START)), $urandom,
                 1'($urandom_range(0, 1)));
      send_req(FN_TICK, $urandom, 1'($urandom_range(0, 1)));
    end
    if ($urandom_range(0, 1)) send_req(FN_STOP, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 6))
      send_req(3'($urandom_range(FN_INSERT, FN_RSV7)),
               $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200),
               1'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [31:0] phase_val [N_PHASES];
    int          phase_end [N_PHASES];
    int          shuf [TBL_DEPTH];
    int          j;
    int          tmp;
    bit          paused;
    paused = 1'b0;
    phase_val = '{32'd1, 32'd65535, 32'd0, 32'h0003_0004, 32'd2, 32'd1, 32'd1, 32'd1};
    phase_end = '{330, 440, 480, 680, 880, 1020, 1160, 1300};
    for (int p = 5; p < N_PHASES; p++) phase_val[p] = $urandom_range(1, 12);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TBL[r])
      send_req(DIR_TBL[r].func, DIR_TBL[r].tv, DIR_TBL[r].frc,
               DIR_TBL[r].pinned, DIR_TBL[r].quiet, DIR_TBL[r].res);

    for (int p = 0; p < N_PHASES; p++) begin
      drain(DRAIN_CYCLES);
      cfg_access(1'b1, phase_val[p]);
      cfg_access(1'b0, 32'd0);
      if (p == 0) begin
        // fill all 64 slots in shuffled order, then overflow and play back
        send_req(FN_STOP, 32'd0, 1'b0);
        send_req(FN_CLEAR, 32'd0, 1'b0);
        for (int i = 0; i < TBL_DEPTH; i++) shuf[i] = i + 1;
        for (int i = TBL_DEPTH - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = shuf[i];
          shuf[i] = shuf[j];
          shuf[j] = tmp;
        end
        foreach (shuf[i]) send_req(FN_INSERT, shuf[i], 1'b0);
        send_req(FN_INSERT, TBL_DEPTH + $urandom_range(1, 1000), 1'b0);
        send_req(FN_INSERT, $urandom_range(1, TBL_DEPTH), 1'b0);
        send_req(FN_START, 32'd0, 1'b0);
        repeat (TBL_DEPTH + 2) send_req(FN_TICK, 32'd0, 1'b0);
      end
      if (p == 3) hold_req = 1'b1;
      while (n_items < phase_end[p]) begin
        if (p == 4 && !paused && n_items >= phase_end[3] + 100) begin
          drain(0);
          paused = 1'b1;
        end
        if ($urandom_range(0, 3) != 0) play_sequence();
        else noise_burst();
      end
    end

    drain(DRAIN_CYCLES);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end
    mode_left--;
    stall_phase++;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        RX_OPEN:     out_stall <= 1'b0;
        RX_COIN:     out_stall <= 1'($urandom_range(0, 1));
        RX_PERIODIC: out_stall <= (stall_phase[1:0] != 2'd0);
        default:     out_stall <= ($urandom_range(0, 15) < 12);
      endcase
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with nothing pending: status %0d index %0d done %0d",
               out_status, out_index, out_done_res);
        fail_cnt++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_cnt++;
        end
        if (out_index !== want.idx) begin
          $error("index: expected %0d, got %0d", want.idx, out_index);
          fail_cnt++;
        end
        if (out_done_res !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, out_done_res);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

endmodule

>>> sim.f
rtl/core/tes_pkg.sv
rtl/core/tes_cmp_unit.sv
rtl/core/tes_event_ram.sv
rtl/core/timed_event_sequencer.sv
dv/timed_event_sequencer_tb.sv
